// ===== hw/rtl/pfr_pkg.sv =====
`default_nettype none
package pfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int WIDTH_W    = 6;
  localparam int VCOUNT_W   = 16;
  localparam int OFFS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IN_BITS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_OFFSET  = 3'd4;

  localparam logic [WIDTH_W-1:0] IN_BITS_RST  = 6'd8;
  localparam logic [WIDTH_W-1:0] OUT_BITS_RST = 6'd8;

  typedef struct packed {
    logic [WIDTH_W-1:0]  in_bits;
    logic [WIDTH_W-1:0]  out_bits;
    logic [VCOUNT_W-1:0] value_count;
    logic [OFFS_W-1:0]   src_offset;
    logic [OFFS_W-1:0]   dst_offset;
  } cfg_t;

  // sequencer to output packer
  typedef struct packed {
    logic start;
    logic put;
    logic put_bit;
    logic put_final;
    logic flush;
  } pack_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pfr_cfg_regs.sv =====
`default_nettype none
module pfr_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pfr_pkg::cfg_t                         cfg
);

  pfr_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pfr_pkg::REG_IN_BITS:     cfg_nxt.in_bits     = cfg_data[pfr_pkg::WIDTH_W-1:0];
        pfr_pkg::REG_OUT_BITS:    cfg_nxt.out_bits    = cfg_data[pfr_pkg::WIDTH_W-1:0];
        pfr_pkg::REG_VALUE_COUNT: cfg_nxt.value_count = cfg_data[pfr_pkg::VCOUNT_W-1:0];
        pfr_pkg::REG_SRC_OFFSET:  cfg_nxt.src_offset  = cfg_data[pfr_pkg::OFFS_W-1:0];
        pfr_pkg::REG_DST_OFFSET:  cfg_nxt.dst_offset  = cfg_data[pfr_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_bits     <= pfr_pkg::IN_BITS_RST;
      cfg_r.out_bits    <= pfr_pkg::OUT_BITS_RST;
      cfg_r.value_count <= '0;
      cfg_r.src_offset  <= '0;
      cfg_r.dst_offset  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pfr_out_pack.sv =====
`default_nettype none
module pfr_out_pack (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pfr_pkg::pack_ctl_t             ctl,
  input  wire logic [pfr_pkg::OFFS_W-1:0]     dst_offset,
  output logic                                step_ok,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pfr_pkg::BYTE_W-1:0]          out_byte,
  output logic                                out_last
);

  logic [pfr_pkg::BYTE_W-1:0] shift_r, shift_nxt;
  logic [pfr_pkg::OFFS_W-1:0] fill_r, fill_nxt;
  logic                       ov_r, ov_nxt;
  logic [pfr_pkg::BYTE_W-1:0] obyte_r, obyte_nxt;
  logic                       olast_r, olast_nxt;
  logic [pfr_pkg::BYTE_W-1:0] placed;

  // a step may emit a byte, so it waits while a stalled byte is held
  assign step_ok   = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

  assign placed = shift_r | (pfr_pkg::BYTE_W'(ctl.put_bit) << fill_r);

  always_comb begin
    shift_nxt = shift_r;
    fill_nxt  = fill_r;
    ov_nxt    = ov_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (ctl.start) begin
      shift_nxt = '0;
      fill_nxt  = dst_offset;
    end else if (ctl.put) begin
      if (fill_r == 3'd7 || ctl.put_final) begin
        ov_nxt    = 1'b1;
        obyte_nxt = placed;
        olast_nxt = ctl.put_final;
        shift_nxt = '0;
        fill_nxt  = '0;
      end else begin
        shift_nxt = placed;
        fill_nxt  = fill_r + 3'd1;
      end
    end else if (ctl.flush && fill_r != '0) begin
      ov_nxt    = 1'b1;
      obyte_nxt = shift_r;
      olast_nxt = 1'b1;
      shift_nxt = '0;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      shift_r <= '0;
      fill_r  <= '0;
    end else begin
      ov_r    <= ov_nxt;
      shift_r <= shift_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/packed_field_width_repacker.sv =====
`default_nettype none
// Bit-serial repacker: converts a byte stream of value_count packed fields of in_bits
// each (LSB first, from bit src_offset) into fields of out_bits each (LSB first, from
// bit dst_offset), keeping the low bits and zero-filling when widening. The first
// request of a job starts it; with value_count zero the request is dropped. Each input
// byte is taken in the idle state and its eight bits are then shifted through the
// single-bit datapath, with zero bits added after every field that ends in the byte
// when widening. The byte that closes a job stops at the bit ending its final field
// and then flushes the last partial byte; every step also waits while a completed
// output byte is held stalled.
// Registers may be written between requests; widths and count take effect on the next bit, offsets at the next job.
module packed_field_width_repacker #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int COUNT_BITS     = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pfr_pkg::BYTE_W-1:0]       in_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pfr_pkg::BYTE_W-1:0]            out_byte,
  output logic                                  out_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW   = $clog2(MAX_FIELD_BITS);
  localparam int EW   = $clog2(MAX_FIELD_BITS + 1);
  localparam int CW   = (EW > pfr_pkg::WIDTH_W) ? EW : pfr_pkg::WIDTH_W;
  localparam int CMPW = ((COUNT_BITS > pfr_pkg::VCOUNT_W) ? COUNT_BITS : pfr_pkg::VCOUNT_W) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BITS  = 2'd1;
  localparam logic [1:0] S_FILL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  pfr_pkg::cfg_t      cfg;
  pfr_pkg::pack_ctl_t ctl;
  logic               step_ok;

  logic [1:0]                  state_r, state_nxt;
  logic                        job_r, job_nxt;
  logic [pfr_pkg::OFFS_W-1:0]  lead_r, lead_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]       fd_r, fd_nxt;
  logic [2:0]                  cnt_r, cnt_nxt;
  logic [pfr_pkg::BYTE_W-1:0]  sr_r, sr_nxt;
  logic                        adv;

  logic [CW-1:0] ib_c, ob_c;
  logic [EW-1:0] ib, ob, p1;
  logic          last_field;

  pfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfr_out_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .dst_offset (cfg.dst_offset),
    .step_ok    (step_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  // width 0 acts as 1, anything above the maximum is clamped
  assign ib_c = (cfg.in_bits == '0) ? CW'(1) :
                ((CW'(cfg.in_bits) > CW'(MAX_FIELD_BITS)) ? CW'(MAX_FIELD_BITS)
                                                          : CW'(cfg.in_bits));
  assign ob_c = (cfg.out_bits == '0) ? CW'(1) :
                ((CW'(cfg.out_bits) > CW'(MAX_FIELD_BITS)) ? CW'(MAX_FIELD_BITS)
                                                           : CW'(cfg.out_bits));
  assign ib = ib_c[EW-1:0];
  assign ob = ob_c[EW-1:0];
  assign p1 = EW'(pos_r) + EW'(1);

  assign last_field = (CMPW'(fd_r) + CMPW'(1)) >= CMPW'(cfg.value_count);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    lead_nxt  = lead_r;
    pos_nxt   = pos_r;
    fd_nxt    = fd_r;
    cnt_nxt   = cnt_r;
    sr_nxt    = sr_r;
    ctl       = '0;
    adv       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (job_r) begin
            sr_nxt    = in_byte;
            cnt_nxt   = '0;
            state_nxt = S_BITS;
          end else if (cfg.value_count != '0) begin
            job_nxt   = 1'b1;
            lead_nxt  = cfg.src_offset;
            pos_nxt   = '0;
            fd_nxt    = '0;
            ctl.start = 1'b1;
            sr_nxt    = in_byte;
            cnt_nxt   = '0;
            state_nxt = S_BITS;
          end
        end
      end
      S_BITS: begin
        if (step_ok) begin
          if (lead_r != '0) begin
            lead_nxt = lead_r - 3'd1;
            adv      = 1'b1;
          end else begin
            if (EW'(pos_r) < ob) begin
              ctl.put       = 1'b1;
              ctl.put_bit   = sr_r[0];
              ctl.put_final = last_field && (p1 == ob) && (ob <= ib);
            end
            if (p1 >= ib) begin
              if (p1 < ob) begin
                // widening: zero bits up to out_bits before the field closes
                pos_nxt   = p1[PW-1:0];
                state_nxt = S_FILL;
              end else begin
                pos_nxt = '0;
                fd_nxt  = fd_r + COUNT_BITS'(1);
                if (last_field) state_nxt = S_FLUSH;
                else adv = 1'b1;
              end
            end else begin
              pos_nxt = p1[PW-1:0];
              adv     = 1'b1;
            end
          end
        end
      end
      S_FILL: begin
        if (step_ok) begin
          ctl.put       = 1'b1;
          ctl.put_bit   = 1'b0;
          ctl.put_final = last_field && (p1 == ob);
          if (p1 >= ob) begin
            pos_nxt = '0;
            fd_nxt  = fd_r + COUNT_BITS'(1);
            if (last_field) begin
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = S_BITS;
              adv       = 1'b1;
            end
          end else begin
            pos_nxt = p1[PW-1:0];
          end
        end
      end
      S_FLUSH: begin
        if (step_ok) begin
          ctl.flush = 1'b1;
          job_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (adv) begin
      sr_nxt  = sr_r >> 1;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= 1'b0;
      lead_r  <= '0;
      pos_r   <= '0;
      fd_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      lead_r  <= lead_nxt;
      pos_r   <= pos_nxt;
      fd_r    <= fd_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pfr_checker.sv =====
`default_nettype none
module pfr_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [pfr_pkg::BYTE_W-1:0]       out_byte,
  input wire logic                             out_last,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output byte changed");

  // bytes are only produced while a request is being worked on
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output byte appeared while idle");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear handshake state");

  a_cfg_always: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind packed_field_width_repacker pfr_checker u_pfr_checker (.*);
`default_nettype wire

// ===== verif/pfr_repack_checker.sv =====
`timescale 1ns / 1ps
module pfr_repack_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [pfr_pkg::BYTE_W-1:0]        in_byte,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [pfr_pkg::BYTE_W-1:0]        out_byte,
  input  logic                              out_last,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                errors,
  output int                                outstanding,
  output int                                bytes_checked
);

  localparam int FIELD_MAX = 32;

  typedef struct packed {
    logic [pfr_pkg::BYTE_W-1:0] data;
    logic                       fin;
  } out_word_t;

  out_word_t       expected_bytes[$];
  pfr_pkg::cfg_t   regs;
  int              bit_in_field;
  int              fields_done;
  int              fill;
  int              skip_left;
  logic [7:0]      shifter;
  bit              job_on;
  int              err_cnt;
  int              chk_cnt;

  function automatic int eff_width(logic [pfr_pkg::WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > FIELD_MAX) return FIELD_MAX;
    return int'(w);
  endfunction

  task automatic push_word(input logic [7:0] d, input bit fin);
    out_word_t w;
    w.data = d;
    w.fin  = fin;
    expected_bytes.push_back(w);
    shifter = '0;
    fill    = 0;
  endtask

  task automatic place_bit(input logic b, input bit fin);
    shifter = shifter | (8'(b) << fill);
    if (fill >= 7 || fin) begin
      push_word(shifter, fin);
    end else begin
      fill++;
    end
  endtask

  // walks one input byte bit by bit, queueing every output byte it completes
  task automatic repack_byte(input logic [7:0] b);
    int ib, ob, p, k, i;
    bit last_field;
    if (!job_on) begin
      if (regs.value_count == 0) return;
      job_on       = 1;
      skip_left    = int'(regs.src_offset);
      fill         = int'(regs.dst_offset);
      bit_in_field = 0;
      fields_done  = 0;
      shifter      = '0;
    end
    for (i = 0; i < 8 && job_on; i++) begin
      ib         = eff_width(regs.in_bits);
      ob         = eff_width(regs.out_bits);
      last_field = (fields_done + 1) >= int'(regs.value_count);
      p          = bit_in_field;
      if (skip_left > 0) begin
        skip_left--;
      end else begin
        if (p < ob) place_bit(b[i], last_field && p + 1 == ob && ob <= ib);
        if (p + 1 >= ib) begin
          // widening: zero-fill the rest of the output field
          for (k = p + 1; k < ob; k++) place_bit(1'b0, last_field && k + 1 == ob);
          bit_in_field = 0;
          fields_done  = (fields_done + 1) & 16'hFFFF;
          if (last_field) begin
            if (fill > 0) push_word(shifter, 1'b1);
            job_on = 0;
          end
        end else begin
          bit_in_field = (p + 1) & 6'h3F;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_word_t w;
    if (!rst_n) begin
      regs.in_bits      = pfr_pkg::IN_BITS_RST;
      regs.out_bits     = pfr_pkg::OUT_BITS_RST;
      regs.value_count  = '0;
      regs.src_offset   = '0;
      regs.dst_offset   = '0;
      bit_in_field      = 0;
      fields_done       = 0;
      fill              = 0;
      skip_left         = 0;
      shifter           = '0;
      job_on            = 0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        chk_cnt++;
        if (expected_bytes.size() == 0) begin
          $error("out_byte: no request outstanding, actual %02h", out_byte);
          err_cnt++;
        end else begin
          w = expected_bytes.pop_front();
          if (out_byte !== w.data) begin
            $error("out_byte: expected %02h, actual %02h", w.data, out_byte);
            err_cnt++;
          end
          if (out_last !== w.fin) begin
            $error("out_last: expected %0d, actual %0d", w.fin, out_last);
            err_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pfr_pkg::REG_IN_BITS:     regs.in_bits     = cfg_data[pfr_pkg::WIDTH_W-1:0];
          pfr_pkg::REG_OUT_BITS:    regs.out_bits    = cfg_data[pfr_pkg::WIDTH_W-1:0];
          pfr_pkg::REG_VALUE_COUNT: regs.value_count = cfg_data[pfr_pkg::VCOUNT_W-1:0];
          pfr_pkg::REG_SRC_OFFSET:  regs.src_offset  = cfg_data[pfr_pkg::OFFS_W-1:0];
          pfr_pkg::REG_DST_OFFSET:  regs.dst_offset  = cfg_data[pfr_pkg::OFFS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) repack_byte(in_byte);
    end
    errors        <= err_cnt;
    outstanding   <= expected_bytes.size();
    bytes_checked <= chk_cnt;
  end

endmodule

// ===== verif/tb_packed_field_width_repacker.sv =====
`timescale 1ns / 1ps
module tb_packed_field_width_repacker;

  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_BYTES = 260;
  localparam logic [pfr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [pfr_pkg::BYTE_W-1:0]     in_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [pfr_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_last;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [pfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data;

  int             errors;
  int             outstanding;
  int             bytes_checked;
  int             sent_bytes = 0;
  int             settings_used = 0;
  int             idle_cycles = 0;
  int             burst_left = 0;
  bit             hold_req = 0;
  bit             steady = 0;
  pfr_pkg::cfg_t  cur;

  always #5 clk = ~clk;

  packed_field_width_repacker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pfr_repack_checker u_repack_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding),
    .bytes_checked (bytes_checked)
  );

  // no handshake of any kind for too long: give up
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_packed_field_width_repacker NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver back-pressure
  initial begin : rx_stall
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  function automatic int eff_bits(logic [pfr_pkg::WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > 32) return 32;
    return int'(w);
  endfunction

  // bytes that carry exactly one whole job at the current settings
  function automatic int job_len();
    return (int'(cur.src_offset) + int'(cur.value_count) * eff_bits(cur.in_bits) + 7) / 8;
  endfunction

  // register value with random junk above the register's width
  function automatic logic [pfr_pkg::CFG_DATA_W-1:0] reg_word(int v, int w);
    logic [pfr_pkg::CFG_DATA_W-1:0] m;
    logic [pfr_pkg::CFG_DATA_W-1:0] r;
    m = (w >= pfr_pkg::CFG_DATA_W) ? '1 : pfr_pkg::CFG_DATA_W'((1 << w) - 1);
    r = pfr_pkg::CFG_DATA_W'($urandom);
    return (r & ~m) | (pfr_pkg::CFG_DATA_W'(v) & m);
  endfunction

  task automatic write_reg(input logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfr_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input int ib, input int ob, input int cnt,
                              input int src, input int dst);
    write_reg(pfr_pkg::REG_IN_BITS,     reg_word(ib, pfr_pkg::WIDTH_W));
    write_reg(pfr_pkg::REG_OUT_BITS,    reg_word(ob, pfr_pkg::WIDTH_W));
    write_reg(pfr_pkg::REG_VALUE_COUNT, reg_word(cnt, pfr_pkg::VCOUNT_W));
    write_reg(pfr_pkg::REG_SRC_OFFSET,  reg_word(src, pfr_pkg::OFFS_W));
    write_reg(pfr_pkg::REG_DST_OFFSET,  reg_word(dst, pfr_pkg::OFFS_W));
    cfg_valid           <= 1'b0;
    cur.in_bits         = pfr_pkg::WIDTH_W'(ib);
    cur.out_bits        = pfr_pkg::WIDTH_W'(ob);
    cur.value_count     = pfr_pkg::VCOUNT_W'(cnt);
    cur.src_offset      = pfr_pkg::OFFS_W'(src);
    cur.dst_offset      = pfr_pkg::OFFS_W'(dst);
    settings_used++;
  endtask

  task automatic send_byte(input logic [pfr_pkg::BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(pfr_pkg::BYTE_W'($urandom));
  endtask

  // sender waits until every expected output byte has been seen, then lets the block settle
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(33, 63);
    if (r == 2) return 32;
    if (r == 3) return 1;
    return $urandom_range(1, 32);
  endfunction

  initial begin
    int rand_bytes;
    int r;
    int cnt;
    rand_bytes = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings have a zero count, so these are dropped
    send_byte(8'h5A);
    send_byte(8'hC3);
    finish_phase();
    write_reg(REG_UNUSED, pfr_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;

    program_regs(8, 8, 3, 0, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    finish_phase();

    // widening with both offsets set
    program_regs(3, 11, 4, 5, 7);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_random(1);
    finish_phase();

    // narrowing hard: the final bytes of the job yield nothing
    program_regs(32, 1, 2, 0, 0);
    send_byte(8'hFF);
    send_random(7);
    finish_phase();

    // zero width acts as one, oversize acts as the maximum
    program_regs(0, 63, 2, 0, 3);
    send_byte(8'hFF);
    finish_phase();

    // single byte giving the largest burst of output
    program_regs(1, 32, 8, 0, 7);
    send_byte(8'hFF);
    finish_phase();

    program_regs(33, 8, 1, 7, 0);
    send_random(5);
    finish_phase();

    // receiver holds off while the sender keeps pushing
    program_regs(8, 8, 40, 0, 0);
    hold_req   = 1;
    steady     = 1;
    burst_left = 0;
    send_random(40);
    steady = 0;
    finish_phase();

    // long job of single-bit fields with both offsets at their maximum
    program_regs(1, 1, 200, 7, 7);
    send_random(job_len());
    finish_phase();

    while (rand_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      cnt = (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 8);
      program_regs(pick_width(), pick_width(), cnt, $urandom_range(0, 7),
                   $urandom_range(0, 7));
      if (cnt == 0) begin
        send_random($urandom_range(1, 4));
      end else begin
        r = $urandom_range(1, 3) * job_len();
        send_random(r);
        rand_bytes += r;
      end
      finish_phase();
    end

    $display("Sent %0d input bytes across %0d register settings; %0d output bytes compared.",
             sent_bytes, settings_used, bytes_checked);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_packed_field_width_repacker OK");
    end else begin
      $display("tb_packed_field_width_repacker NOT OK");
    end
    $finish;
  end

endmodule
